// File: rtl/rlpe_pkg.sv
// Shared constants and types for the run-length packet encoder.
// No dependencies; imported by run_length_packet_encoder.
package rlpe_pkg;

	localparam int BYTE_W         = 8;
	localparam int LANES          = 8;
	localparam int LANE_W         = 3;
	localparam int WORD_W         = LANES * BYTE_W;
	localparam int CNT_W          = 4;
	localparam int OUT_W          = 72;
	localparam int MAX_PACKET_DEF = 127;
	localparam int MIN_RUN_DEF    = 3;

	typedef logic [BYTE_W-1:0] byte_t;

	localparam byte_t RUN_MARK = 8'h80;

endpackage

// File: rtl/run_length_packet_encoder.sv
// Run-length packet encoder top level: sequencer, literal buffer memory and word packer.
// Depends on rlpe_pkg.
//
// Slave channel: one message byte per word on s_tdata[7:0]; s_tlast marks the final byte.
// Master channel: m_tdata[63:0] holds up to eight coded bytes, earliest in lane 0, with
// m_tdata[67:64] the number of valid lanes; m_tlast marks the last word of the message.
// A byte that only starts or extends a run of equal bytes is taken in the idle state and the
// next byte is accepted right after. A byte that moves undecided bytes into the literal
// buffer writes them one by one; with a run threshold above the packet size every byte is
// added to the literal buffer directly. Coded bytes are settled one per cycle while the
// packer has room and the output register can take its words (the single read port of
// the literal buffer and the one-byte-wide packer set this rate); moving a full word to
// the output register holds the packer. A full literal packet holds 128 coded bytes.
// Coded bytes leave through a one-word output register; when the receiver stalls, the
// packer fills up and the sequencer waits, so no byte is lost. s_tready is low while a
// byte is being worked on.
// Reset clears all lengths, the packer and the output register; the literal buffer is not
// cleared, since only entries written within the open packet are ever read.
module run_length_packet_encoder #(
	parameter int MAX_PACKET = rlpe_pkg::MAX_PACKET_DEF,
	parameter int MIN_RUN    = rlpe_pkg::MIN_RUN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [rlpe_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [rlpe_pkg::OUT_W-1:0]  m_tdata,   // [63:0] coded_bytes, [67:64] byte_count
	output logic                        m_tlast
);
	import rlpe_pkg::*;

	localparam int LIM = (MAX_PACKET > MIN_RUN) ? MAX_PACKET : MIN_RUN;
	localparam int LW  = $clog2(LIM + 1);
	localparam int AW  = $clog2(MAX_PACKET);
	localparam bit NO_RUNS = (MIN_RUN > MAX_PACKET);
	localparam logic [LW-1:0] MAX_L = LW'(MAX_PACKET);
	localparam logic [LW-1:0] MIN_L = LW'(MIN_RUN);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(LANES);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ADDB   = 4'd1;
	localparam logic [3:0] S_UNDEC  = 4'd2;
	localparam logic [3:0] S_SETB   = 4'd3;
	localparam logic [3:0] S_CHKRUN = 4'd4;
	localparam logic [3:0] S_RUNH   = 4'd5;
	localparam logic [3:0] S_RUNV   = 4'd6;
	localparam logic [3:0] S_LCNT   = 4'd7;
	localparam logic [3:0] S_LDAT   = 4'd8;
	localparam logic [3:0] S_TAIL   = 4'd9;
	localparam logic [3:0] S_TLIT   = 4'd10;
	localparam logic [3:0] S_FLUSH  = 4'd11;

	logic [3:0]        state_q, lit_ret_q, run_ret_q, und_ret_q;
	logic [LW-1:0]     lit_len_q, run_len_q, idx_q;
	byte_t             run_val_q, b_q, rd_q;
	logic              last_q, set_new_q;

	logic [WORD_W-1:0] pk_data_q, out_data_q;
	logic [CNT_W-1:0]  pk_cnt_q, out_cnt_q;
	logic              out_valid_q, out_last_q;

	byte_t             lit_mem [MAX_PACKET];

	logic [LW-1:0]     ll_inc, rl_inc, idx_inc;
	logic              acc, in_eq, can_put, put_state, put_en, out_free, mv;
	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	byte_t             wr_data, put_byte;

	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign in_eq    = (s_tdata == run_val_q);
	assign ll_inc   = lit_len_q + 1'b1;
	assign rl_inc   = run_len_q + 1'b1;
	assign idx_inc  = idx_q + 1'b1;
	assign can_put  = (pk_cnt_q != FULL);
	assign out_free = !out_valid_q || m_tready;

	assign wr_en   = (state_q == S_ADDB) || (state_q == S_UNDEC && run_len_q != '0);
	assign wr_data = (state_q == S_ADDB) ? b_q : run_val_q;
	assign wr_addr = lit_len_q[AW-1:0];
	assign rd_en   = can_put && ((state_q == S_LCNT) ||
		(state_q == S_LDAT && idx_inc != lit_len_q));
	assign rd_addr = (state_q == S_LCNT) ? '0 : idx_inc[AW-1:0];

	always_comb begin
		put_state = 1'b1;
		put_byte  = rd_q;
		unique case (state_q)
			S_RUNH: put_byte = RUN_MARK | BYTE_W'(run_len_q);
			S_RUNV: put_byte = run_val_q;
			S_LCNT: put_byte = BYTE_W'(lit_len_q);
			S_LDAT: put_byte = rd_q;
			default: put_state = 1'b0;
		endcase
		put_en = put_state && can_put;
	end

	assign mv = out_free && (((pk_cnt_q == FULL) && put_state) ||
		(state_q == S_FLUSH && pk_cnt_q != '0));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lit_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= lit_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			lit_ret_q <= S_IDLE;
			run_ret_q <= S_IDLE;
			und_ret_q <= S_IDLE;
			lit_len_q <= '0;
			run_len_q <= '0;
			idx_q     <= '0;
			run_val_q <= '0;
			b_q       <= '0;
			last_q    <= 1'b0;
			set_new_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (acc) begin
					b_q    <= s_tdata;
					last_q <= s_tlast;
					if (NO_RUNS) begin
						state_q <= S_ADDB;
					end else if (run_len_q >= MIN_L) begin
						if (in_eq) begin
							run_len_q <= rl_inc;
							if (rl_inc >= MAX_L) begin
								run_ret_q <= S_TAIL;
								set_new_q <= 1'b0;
								state_q   <= S_RUNH;
							end else if (s_tlast) begin
								state_q <= S_TAIL;
							end
						end else begin
							run_ret_q <= S_TAIL;
							set_new_q <= 1'b1;
							state_q   <= S_RUNH;
						end
					end else if (run_len_q != '0 && in_eq) begin
						run_len_q <= rl_inc;
						if (rl_inc >= MIN_L) begin
							if (lit_len_q != '0) begin
								lit_ret_q <= S_CHKRUN;
								state_q   <= S_LCNT;
							end else begin
								state_q <= S_CHKRUN;
							end
						end else if (s_tlast) begin
							state_q <= S_TAIL;
						end
					end else if (run_len_q != '0) begin
						und_ret_q <= S_SETB;
						state_q   <= S_UNDEC;
					end else begin
						run_val_q <= s_tdata;
						run_len_q <= LW'(1);
						if (s_tlast) begin
							state_q <= S_TAIL;
						end
					end
				end
				S_ADDB: begin
					lit_len_q <= ll_inc;
					lit_ret_q <= S_TAIL;
					state_q   <= (ll_inc >= MAX_L) ? S_LCNT : S_TAIL;
				end
				S_UNDEC: begin
					if (run_len_q == '0) begin
						state_q <= und_ret_q;
					end else begin
						run_len_q <= run_len_q - 1'b1;
						lit_len_q <= ll_inc;
						if (ll_inc >= MAX_L) begin
							lit_ret_q <= S_UNDEC;
							state_q   <= S_LCNT;
						end
					end
				end
				S_SETB: begin
					run_val_q <= b_q;
					run_len_q <= LW'(1);
					state_q   <= S_TAIL;
				end
				S_CHKRUN: begin
					run_ret_q <= S_TAIL;
					set_new_q <= 1'b0;
					state_q   <= (run_len_q >= MAX_L) ? S_RUNH : S_TAIL;
				end
				S_RUNH: if (can_put) begin
					state_q <= S_RUNV;
				end
				S_RUNV: if (can_put) begin
					if (set_new_q) begin
						run_val_q <= b_q;
						run_len_q <= LW'(1);
					end else begin
						run_len_q <= '0;
					end
					state_q <= run_ret_q;
				end
				S_LCNT: if (can_put) begin
					idx_q   <= '0;
					state_q <= S_LDAT;
				end
				S_LDAT: if (can_put) begin
					if (idx_inc == lit_len_q) begin
						lit_len_q <= '0;
						state_q   <= lit_ret_q;
					end else begin
						idx_q <= idx_inc;
					end
				end
				S_TAIL: begin
					if (!last_q) begin
						state_q <= S_FLUSH;
					end else if (!NO_RUNS && run_len_q >= MIN_L) begin
						run_ret_q <= S_TLIT;
						set_new_q <= 1'b0;
						state_q   <= S_RUNH;
					end else if (run_len_q != '0) begin
						und_ret_q <= S_TLIT;
						state_q   <= S_UNDEC;
					end else begin
						state_q <= S_TLIT;
					end
				end
				S_TLIT: begin
					run_val_q <= '0;
					lit_ret_q <= S_FLUSH;
					state_q   <= (lit_len_q != '0) ? S_LCNT : S_FLUSH;
				end
				S_FLUSH: if (pk_cnt_q == '0) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// byte packer and output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_data_q   <= '0;
			pk_cnt_q    <= '0;
			out_data_q  <= '0;
			out_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (mv) begin
			out_data_q  <= pk_data_q;
			out_cnt_q   <= pk_cnt_q;
			out_last_q  <= (state_q == S_FLUSH) && last_q;
			out_valid_q <= 1'b1;
			pk_data_q   <= '0;
			pk_cnt_q    <= '0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (put_en) begin
				pk_data_q[{pk_cnt_q[LANE_W-1:0], 3'b000} +: BYTE_W] <= put_byte;
				pk_cnt_q <= pk_cnt_q + 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - WORD_W - CNT_W){1'b0}}, out_cnt_q, out_data_q};
	assign m_tlast  = out_last_q;

	a_idle_packer_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (pk_cnt_q == '0))
		else $error("packer holds bytes while idle");

	a_run_excludes_literal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !NO_RUNS && run_len_q >= MIN_L) |-> (lit_len_q == '0))
		else $error("open literal packet during a run");

	a_idle_lengths: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (lit_len_q < MAX_L && run_len_q < MAX_L))
		else $error("full packet left unsent");

	a_final_state_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH && last_q) |-> (lit_len_q == '0 && run_len_q == '0))
		else $error("state not cleared at end of message");

	a_final_only_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(mv && put_state) |=> !out_last_q)
		else $error("final flag on a mid-message word");

endmodule
